### rtl/core/assert_macros.svh
// Assertion macros shared by the string escaper RTL.
// Include with the bare file name; each use stands on its own line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define JSESC_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define JSESC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/jsesc_pkg.sv
// Types and constants of the JSON string escaper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package jsesc_pkg;

    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_ASCII_TOP = 8'h80;
    localparam logic [7:0] C_CTRL_TOP  = 8'h20;
    localparam logic [7:0] C_TERM_BYTE = 8'h00;

    localparam logic [20:0] C_MIN_CP2   = 21'h00080;
    localparam logic [20:0] C_MIN_CP3   = 21'h00800;
    localparam logic [20:0] C_MIN_CP4   = 21'h10000;
    localparam logic [20:0] C_SURR_LO   = 21'h0D800;
    localparam logic [20:0] C_SURR_HI   = 21'h0DFFF;
    localparam logic [20:0] C_CP_MAX    = 21'h10FFFF;

    localparam logic [15:0] C_CAP_RESET = 16'd256;

    // An accepted byte becomes one job or none: U+FFFD replacements, then
    // an optional unit of up to four bytes, then an optional terminator.
    typedef struct packed {
        logic [2:0]      reps;
        logic [3:0][7:0] ubytes;
        logic [2:0]      ulen;
        logic            term;
        logic            trunc;
    } t_job;

    // Byte of U+FFFD (EF BF BD) at the given phase.
    function automatic logic [7:0] rep_byte(input logic [1:0] ph);
        logic [7:0] b;
        case (ph)
            2'd0:    b = 8'hEF;
            2'd1:    b = 8'hBF;
            default: b = 8'hBD;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/jsesc_front.sv
// Front end: takes input bytes, tracks UTF-8 sequences and output budget,
// and turns each byte into at most one job. Depends on jsesc_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module jsesc_front
    import jsesc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic [15:0] i_cap,
    output logic             o_job_push,
    output t_job             o_job
);

    logic [2:0][7:0] r_held;
    logic [1:0]      r_hcnt;
    logic [2:0]      r_slen;
    logic [20:0]     r_acc;
    logic [15:0]     r_bw;
    logic            r_stop;

    logic [1:0]      n_hcnt;
    logic [2:0]      n_slen;
    logic [20:0]     n_acc;
    logic [15:0]     n_bw;
    logic            n_stop;
    logic            held_we;
    logic [1:0]      held_idx;

    logic            held;
    logic            cont;
    logic [20:0]     acc_ext;
    logic            complete;
    logic            cp_ok;
    logic [7:0]      b;

    logic [2:0]      raw_reps;
    logic [3:0][7:0] raw_ub;
    logic [2:0]      raw_ulen;
    logic            raw_term;
    logic            lead2, lead3, lead4;
    logic            fresh;

    logic [16:0]     bw17, cap17, bw_r;
    logic [3:0]      fit;
    logic [2:0]      f;
    logic            rep_short;
    logic            ufit;
    logic            term_emit;
    logic [16:0]     bw_sum;
    logic            stop_now;

    assign b        = i_in_byte;
    assign held     = (r_hcnt != 2'd0);
    assign cont     = (b[7:6] == 2'b10);
    assign acc_ext  = {r_acc[14:0], b[5:0]};
    assign complete = ({1'b0, r_hcnt} + 3'd1) >= r_slen;
    assign lead2    = (b[7:5] == 3'b110);
    assign lead3    = (b[7:4] == 4'b1110);
    assign lead4    = (b[7:3] == 5'b11110);
    assign fresh    = !(held && cont);

    always_comb begin
        cp_ok = 1'b1;
        if (r_slen == 3'd2 && acc_ext < C_MIN_CP2) cp_ok = 1'b0;
        if (r_slen == 3'd3 && acc_ext < C_MIN_CP3) cp_ok = 1'b0;
        if (r_slen == 3'd4 && acc_ext < C_MIN_CP4) cp_ok = 1'b0;
        if (acc_ext >= C_SURR_LO && acc_ext <= C_SURR_HI) cp_ok = 1'b0;
        if (acc_ext > C_CP_MAX) cp_ok = 1'b0;
    end

    // Classify the byte into replacements, one unit and a terminator.
    always_comb begin
        raw_reps = 3'd0;
        raw_ub   = '0;
        raw_ulen = 3'd0;
        raw_term = 1'b0;
        if (!fresh) begin
            if (complete) begin
                if (cp_ok) begin
                    for (int i = 0; i < 3; i++) begin
                        raw_ub[i] = (2'(i) < r_hcnt) ? r_held[i] : b;
                    end
                    raw_ub[3] = b;
                    raw_ulen  = {1'b0, r_hcnt} + 3'd1;
                end else begin
                    raw_reps = r_slen;
                end
            end
        end else begin
            // A broken sequence turns every held byte into a replacement.
            raw_reps = {1'b0, r_hcnt};
            if (b == C_TERM_BYTE) begin
                raw_term = 1'b1;
            end else if (b == C_QUOTE || b == C_BACKSLASH) begin
                raw_ub[0] = C_BACKSLASH;
                raw_ub[1] = b;
                raw_ulen  = 3'd2;
            end else if (b < C_CTRL_TOP) begin
                raw_ub[0] = C_SPACE;
                raw_ulen  = 3'd1;
            end else if (b < C_ASCII_TOP) begin
                raw_ub[0] = b;
                raw_ulen  = 3'd1;
            end else if (!(lead2 || lead3 || lead4)) begin
                raw_reps = {1'b0, r_hcnt} + 3'd1;
            end
        end
    end

    // Budget check: each replacement is a unit of its own, then the unit.
    assign bw17  = {1'b0, r_bw};
    assign cap17 = {1'b0, i_cap};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fit[i] = !r_stop && (3'(i) < raw_reps)
                     && ((bw17 + 17'(3 * (i + 1))) < cap17);
        end
    end

    assign f         = 3'(fit[0]) + 3'(fit[1]) + 3'(fit[2]) + 3'(fit[3]);
    assign rep_short = (f != raw_reps);
    assign bw_r      = bw17 + 17'(f) + 17'({f, 1'b0});
    assign ufit      = !r_stop && !rep_short && (raw_ulen != 3'd0)
                       && ((bw_r + 17'(raw_ulen)) < cap17);
    assign term_emit = raw_term && (i_cap != 16'd0);
    assign bw_sum    = bw_r + (ufit ? 17'(raw_ulen) : 17'd0);

    // Stop flag as it stands once this byte's beats are counted; the
    // terminator reports it before the string state is cleared.
    assign stop_now  = r_stop || rep_short || ((raw_ulen != 3'd0) && !ufit);

    always_comb begin
        n_stop = stop_now;
        n_bw   = bw_sum[15:0];
        n_hcnt = r_hcnt;
        n_slen = r_slen;
        n_acc  = r_acc;
        held_we  = 1'b0;
        held_idx = 2'd0;
        if (!fresh) begin
            if (complete) begin
                n_hcnt = 2'd0;
                n_slen = 3'd0;
            end else begin
                held_we  = 1'b1;
                held_idx = r_hcnt;
                n_hcnt   = r_hcnt + 2'd1;
                n_acc    = acc_ext;
            end
        end else begin
            n_hcnt = 2'd0;
            n_slen = 3'd0;
            if (lead2) begin
                n_slen = 3'd2; n_acc = {16'd0, b[4:0]}; n_hcnt = 2'd1; held_we = 1'b1;
            end else if (lead3) begin
                n_slen = 3'd3; n_acc = {17'd0, b[3:0]}; n_hcnt = 2'd1; held_we = 1'b1;
            end else if (lead4) begin
                n_slen = 3'd4; n_acc = {18'd0, b[2:0]}; n_hcnt = 2'd1; held_we = 1'b1;
            end
            if (raw_term) begin
                n_bw   = 16'd0;
                n_stop = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= 2'd0;
            r_slen <= 3'd0;
            r_acc  <= 21'd0;
            r_bw   <= 16'd0;
            r_stop <= 1'b0;
        end else if (i_accept) begin
            r_hcnt <= n_hcnt;
            r_slen <= n_slen;
            r_acc  <= n_acc;
            r_bw   <= n_bw;
            r_stop <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && held_we) begin
            r_held[held_idx] <= b;
        end
    end

    always_comb begin
        o_job.reps   = f;
        o_job.ubytes = raw_ub;
        o_job.ulen   = ufit ? raw_ulen : 3'd0;
        o_job.term   = term_emit;
        o_job.trunc  = stop_now;
    end

    assign o_job_push = i_accept && ((f != 3'd0) || ufit || term_emit);

    `JSESC_ASSERT_IMPLY(a_hcnt_below_len, i_clk, i_rst_n, r_hcnt != 2'd0, {1'b0, r_hcnt} < r_slen, "held count not below sequence length")
    `JSESC_ASSERT_IMPLY(a_len_when_held, i_clk, i_rst_n, r_hcnt != 2'd0, r_slen >= 3'd2, "bytes held without a sequence length")

endmodule

`default_nettype wire

### rtl/core/jsesc_queue.sv
// Short job queue between the front end and the byte generator.
// Depends on jsesc_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module jsesc_queue
    import jsesc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/jsesc_back.sv
// Byte generator: expands the job at the queue head into output beats and
// holds them in an output register. Depends on jsesc_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module jsesc_back
    import jsesc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    input  wire logic pop,
    output logic      empty,
    output logic [7:0] o_out_byte,
    output logic      o_is_terminator,
    output logic      o_was_truncated,
    output logic      o_last_of_run
);

    logic [2:0] r_rep;
    logic [1:0] r_ph;
    logic [2:0] r_up;
    logic       r_ovalid;

    logic [2:0] n_rep;
    logic [1:0] n_ph;
    logic [2:0] n_up;

    logic       in_rep, in_unit, on_term;
    logic       last;
    logic       load;
    logic [7:0] beat_byte;

    assign in_rep  = (r_rep < i_job.reps);
    assign in_unit = !in_rep && (r_up < i_job.ulen);
    assign on_term = !in_rep && !in_unit;

    always_comb begin
        n_rep = r_rep;
        n_ph  = r_ph;
        n_up  = r_up;
        if (in_rep) begin
            if (r_ph == 2'd2) begin
                n_ph  = 2'd0;
                n_rep = r_rep + 3'd1;
            end else begin
                n_ph = r_ph + 2'd1;
            end
        end else if (in_unit) begin
            n_up = r_up + 3'd1;
        end
    end

    // Last beat of a job: the terminator, or the final data beat of a job
    // that carries no terminator.
    assign last = on_term
                  || (!i_job.term && (n_rep >= i_job.reps) && (n_up >= i_job.ulen));

    always_comb begin
        if (in_rep) begin
            beat_byte = rep_byte(r_ph);
        end else if (in_unit) begin
            beat_byte = i_job.ubytes[r_up[1:0]];
        end else begin
            beat_byte = C_TERM_BYTE;
        end
    end

    assign empty     = !r_ovalid;
    assign load      = i_job_valid && (!r_ovalid || pop);
    assign o_job_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep    <= 3'd0;
            r_ph     <= 2'd0;
            r_up     <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                if (last) begin
                    r_rep <= 3'd0;
                    r_ph  <= 2'd0;
                    r_up  <= 3'd0;
                end else begin
                    r_rep <= n_rep;
                    r_ph  <= n_ph;
                    r_up  <= n_up;
                end
            end else if (pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_out_byte      <= beat_byte;
            o_is_terminator <= on_term;
            o_was_truncated <= on_term && i_job.trunc;
            o_last_of_run   <= last;
        end
    end

    `JSESC_ASSERT_IMPLY(a_term_is_last, i_clk, i_rst_n, !empty && o_is_terminator, o_last_of_run, "terminator beat not marked last")
    `JSESC_ASSERT_IMPLY(a_progress_in_job, i_clk, i_rst_n, i_job_valid, (r_rep <= i_job.reps) && (r_up <= i_job.ulen), "byte generator ran past its job")

endmodule

`default_nettype wire

### rtl/core/json_string_escape_utf8_validate.sv
// JSON string escaper with UTF-8 validation.
// Input side is a queue: a byte beat is taken when push is high and full is
// low. Result side is a queue: the oldest result sits on the o_ ports while
// empty is low and is taken when pop is high. One input byte gives zero to
// twelve result beats; the last one carries o_last_of_run.
// Throughput: one input byte per cycle while full is low, and one result
// beat per cycle from the byte generator while the receiver pops; a job
// holds the generator until its last beat, and the job queue (QUEUE_DEPTH
// jobs) lets the input run ahead. A byte's job is queued, then its beats
// are registered. Capacity is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while the block is idle, which the block does
// not enforce. It resets to 256. Reset empties the queues and clears all
// string state. When the receiver stalls, the output register holds its
// beat, the job queue fills, and full rises to stop the sender.
// Depends on jsesc_pkg, jsesc_front, jsesc_queue and jsesc_back.
`timescale 1ns / 1ps
`default_nettype none

module json_string_escape_utf8_validate
    import jsesc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_is_terminator,
    output logic             o_was_truncated,
    output logic             o_last_of_run
);

    logic [15:0] r_cap;
    logic        accept;
    logic        job_push;
    t_job        job_in;
    logic        job_valid;
    t_job        job_head;
    logic        job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= C_CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    assign accept = push && !full;

    jsesc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_cap      (r_cap),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    jsesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (job_head)
    );

    jsesc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job_head),
        .o_job_pop       (job_pop),
        .pop             (pop),
        .empty           (empty),
        .o_out_byte      (o_out_byte),
        .o_is_terminator (o_is_terminator),
        .o_was_truncated (o_was_truncated),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

`default_nettype wire
